### rtl/lfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg: shared types and constants of the frame-store refresh block
// Request and frame payload structs, the action codes, the controller states
// and the helpers that split bytes into the two-nibble serial form.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;

  // The store is kept as 32-bit words of four bytes each. A data chunk is
  // exactly one word, so one read serves one chunk.
  localparam int ROW_BYTES   = PANEL_WIDTH / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int WORD_BYTES  = 4;
  localparam int WORD_W      = WORD_BYTES * 8;
  localparam int STORE_WORDS = STORE_BYTES / WORD_BYTES;
  localparam int WORD_AW     = $clog2(STORE_WORDS);

  localparam logic [7:0] SYNC_CMD     = 8'hF8;
  localparam logic [7:0] SYNC_DATA    = 8'hFA;
  localparam logic [7:0] ROW_CMD_BASE = 8'h80;
  localparam logic [7:0] COL_CMD      = 8'h80;

  localparam logic [3:0] BYTES_SINGLE = 4'd2;
  localparam logic [3:0] BYTES_CHUNK  = 4'd8;

  // Frames of one row refresh: row command, column command, eight chunks.
  localparam int         FRM_CNT_W         = 4;
  localparam logic [3:0] FRAME_ROW_CMD     = 4'd0;
  localparam logic [3:0] FRAME_COL_CMD     = 4'd1;
  localparam logic [3:0] FIRST_CHUNK_FRAME = 4'd2;
  localparam logic [3:0] LAST_FRAME        = 4'd9;

  typedef enum logic [1:0] {
    ACT_SET_PIXEL = 2'd0,
    ACT_REFRESH   = 2'd1,
    ACT_CMD_BYTE  = 2'd2,
    ACT_DATA_BYTE = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    logic       pixel_on;
    logic [4:0] row_index;
    logic [7:0] raw_value;
  } req_t;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [63:0] body;
    logic [3:0]  body_bytes;
    logic        last_of_run;
  } frm_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_FRM_RD,
    ST_FRM_LOAD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_req;
    logic rd_en;
    logic wr_en;
    logic out_load;
    logic frame_clr;
    logic frame_inc;
  } lfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    frame_done;
    logic    out_free;
  } lfr_status_t;

  // High nibble first, then the low nibble shifted up.
  function automatic logic [15:0] split_byte(input logic [7:0] v);
    split_byte = {v[3:0], 4'b0000, v[7:4], 4'b0000};
  endfunction

  function automatic logic [63:0] chunk_body(input logic [WORD_W-1:0] w);
    logic [63:0] b;
    b = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      b[16*i +: 16] = split_byte(w[8*i +: 8]);
    end
    chunk_body = b;
  endfunction

endpackage

### rtl/lfr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_datapath: frame store, request register and frame output register
// Holds the frame store as words with per-word valid bits, performs the
// pixel read-modify-write and assembles each serial frame.
// ----------------------------------------------------------------------------
module lfr_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  lfr_pkg::req_t        req_data,
  input  lfr_pkg::lfr_cmd_t    cmd,
  output lfr_pkg::lfr_status_t status,
  output logic                 frm_valid,
  input  logic                 frm_ready,
  output lfr_pkg::frm_t        frm_data
);
  import lfr_pkg::*;

  req_t                 req_q;
  logic [FRM_CNT_W-1:0] frame_cnt;
  logic [WORD_W-1:0]    mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] word_vld;
  logic [WORD_W-1:0]    rd_word;
  logic                 rd_vld;
  logic [WORD_W-1:0]    rd_eff;
  logic [WORD_W-1:0]    wr_word;
  logic [WORD_AW-1:0]   addr;
  logic [FRM_CNT_W-1:0] chunk_idx;
  logic [4:0]           bit_pos;
  frm_t                 frm_next;

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      req_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt <= '0;
    end else if (cmd.frame_clr) begin
      frame_cnt <= '0;
    end else if (cmd.frame_inc) begin
      frame_cnt <= frame_cnt + 1'b1;
    end
  end

  // Pixel word: {row, column byte / 4}. Chunk word: {half, row, chunk}.
  assign chunk_idx = frame_cnt - FIRST_CHUNK_FRAME;

  always_comb begin
    if (req_q.action == ACT_SET_PIXEL) begin
      addr = {req_q.pixel_y, req_q.pixel_x[6:5]};
    end else begin
      addr = {chunk_idx[2], req_q.row_index, chunk_idx[1:0]};
    end
  end

  // Byte lane from pixel_x[4:3]; MSB of a byte is the leftmost pixel.
  assign bit_pos = {req_q.pixel_x[4:3], ~req_q.pixel_x[2:0]};
  assign rd_eff  = rd_vld ? rd_word : '0;

  always_comb begin
    wr_word          = rd_eff;
    wr_word[bit_pos] = req_q.pixel_on;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wr_word;
    end
    if (cmd.rd_en) begin
      rd_word <= mem[addr];
    end
  end

  // Words never written read as zero, which stands for the cleared store.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        word_vld[addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld <= word_vld[addr];
      end
    end
  end

  always_comb begin
    frm_next = '0;
    if (req_q.action == ACT_REFRESH) begin
      priority if (frame_cnt == FRAME_ROW_CMD) begin
        frm_next.sync_byte  = SYNC_CMD;
        frm_next.body       = {48'd0, split_byte(ROW_CMD_BASE + {3'b000, req_q.row_index})};
        frm_next.body_bytes = BYTES_SINGLE;
      end else if (frame_cnt == FRAME_COL_CMD) begin
        frm_next.sync_byte  = SYNC_CMD;
        frm_next.body       = {48'd0, split_byte(COL_CMD)};
        frm_next.body_bytes = BYTES_SINGLE;
      end else begin
        frm_next.sync_byte  = SYNC_DATA;
        frm_next.body       = chunk_body(rd_eff);
        frm_next.body_bytes = BYTES_CHUNK;
      end
      frm_next.last_of_run = (frame_cnt == LAST_FRAME);
    end else begin
      frm_next.sync_byte   = (req_q.action == ACT_CMD_BYTE) ? SYNC_CMD : SYNC_DATA;
      frm_next.body        = {48'd0, split_byte(req_q.raw_value)};
      frm_next.body_bytes  = BYTES_SINGLE;
      frm_next.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (cmd.out_load) begin
      frm_valid <= 1'b1;
    end else if (frm_ready) begin
      frm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frm_data <= frm_next;
    end
  end

  assign status.action     = req_q.action;
  assign status.frame_done = (frame_cnt == LAST_FRAME);
  assign status.out_free   = !frm_valid || frm_ready;

endmodule

### rtl/lfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_ctrl: sequencing state machine
// Accepts one request at a time and steps the datapath through the pixel
// update or through the frames that the request causes.
// ----------------------------------------------------------------------------
module lfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  lfr_pkg::action_t     req_action,
  output logic                 req_ready,
  input  lfr_pkg::lfr_status_t status,
  output lfr_pkg::lfr_cmd_t    cmd
);
  import lfr_pkg::*;

  state_t state;
  state_t state_next;
  logic   run_end;

  assign run_end = (status.action != ACT_REFRESH) || status.frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req_action)
            ACT_SET_PIXEL: state_next = ST_PIX_RD;
            ACT_REFRESH:   state_next = ST_FRM_RD;
            ACT_CMD_BYTE,
            ACT_DATA_BYTE: state_next = ST_FRM_LOAD;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD:   state_next = ST_PIX_WR;
      ST_PIX_WR:   state_next = ST_IDLE;
      ST_FRM_RD:   state_next = ST_FRM_LOAD;
      ST_FRM_LOAD: begin
        if (status.out_free) begin
          state_next = run_end ? ST_IDLE : ST_FRM_RD;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready     = 1'b1;
        cmd.take_req  = req_valid;
        cmd.frame_clr = req_valid;
      end
      ST_PIX_RD:   cmd.rd_en = 1'b1;
      ST_PIX_WR:   cmd.wr_en = 1'b1;
      ST_FRM_RD:   cmd.rd_en = 1'b1;
      ST_FRM_LOAD: begin
        cmd.out_load  = status.out_free;
        cmd.frame_inc = status.out_free && !run_end;
      end
      default: begin
        cmd       = '0;
        req_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("frame loaded while the output register is occupied");

  a_last_frame_ends_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FRM_LOAD && status.out_free && status.frame_done) |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after the last frame");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> $past(cmd.rd_en))
    else $error("pixel write without a preceding word read");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("new request accepted while the previous one is in progress");
`endif

endmodule

### rtl/lcd_framebuffer_serial_refresh_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_framebuffer_serial_refresh_core: frame store to serial frame converter
// Keeps a 128x64 one-bit frame store and emits the serial controller frames
// for row refreshes and for raw command and data bytes.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on req_valid/req_ready/req_data and frames leave on
// frm_valid/frm_ready/frm_data, both with a valid/ready handshake. One request
// is worked on at a time; req_ready is high only while the block is idle.
// A set-pixel request updates one bit of the store and produces no frame; it
// occupies the block for its accept, word read and word write steps.
// A raw command or data request yields one frame, loaded into the output
// register in the load state that follows acceptance, once the register is
// free. A row refresh yields ten frames, the last one marked with last_of_run.
// For each frame a read state reads the store word for the chunk from the
// single store port, and a load state then loads the frame into the output
// register. A frame waiting in the output register does not block the next
// store read; if the receiver holds frm_ready low, the sequencer waits with
// the next frame and nothing is lost or repeated. Reset clears the valid
// bits of all 256 store words at once, so the whole store reads as zero
// straight after reset with no clearing pass; the block is ready for
// requests as soon as reset is released.
// ----------------------------------------------------------------------------
module lcd_framebuffer_serial_refresh_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lfr_pkg::req_t req_data,
  output logic          frm_valid,
  input  logic          frm_ready,
  output lfr_pkg::frm_t frm_data
);
  import lfr_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  lfr_cmd_t    cmd;
  lfr_status_t status;

  // The sequencer decides on the action of the incoming request directly,
  // since the request register is only loaded at acceptance.
  lfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req_data.action),
    .req_ready  (req_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath owns the frame store, the request register, the frame
  // counter and the output register that parts the two channels.
  lfr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .status    (status),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_data  (frm_data)
  );

endmodule
